/* rtl/budgeted_lru_store_with_pinning_assert.svh */
// Assertion macros used by the port-level checker.
`ifndef BUDGETED_LRU_STORE_WITH_PINNING_ASSERT_SVH
`define BUDGETED_LRU_STORE_WITH_PINNING_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define BLS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define BLS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* rtl/bls_pkg.sv */
// Package: shared constants, codes and controller/datapath command types.
package bls_pkg;
  localparam int ENTRIES_DEF   = 16;
  localparam int KEY_BITS_DEF  = 32;
  localparam int SIZE_BITS_DEF = 32;
  localparam logic [31:0] BUDGET_RESET = 32'd65536;
  // Wide enough to hold the exact sum of many pinned entries.
  localparam int USED_BITS = 64;

  localparam logic [2:0] REQ_PUT   = 3'd0;
  localparam logic [2:0] REQ_GET   = 3'd1;
  localparam logic [2:0] REQ_PIN   = 3'd2;
  localparam logic [2:0] REQ_UNPIN = 3'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_EVICTED   = 3'd2;
  localparam logic [2:0] ST_FORMAT    = 3'd3;
  localparam logic [2:0] ST_TOO_LARGE = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture request, start key scan
    logic scan_step; // advance lookup scan one slot
    logic apply;     // apply the request effect on the found/free slot
    logic vic_start; // begin a victim scan
    logic vic_step;  // advance victim scan one slot
    logic evict;     // evict the chosen victim
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic vic_done;
    logic have_victim;
    logic over_budget;
    logic [2:0] req;
  } stat_t;
endpackage

/* rtl/bls_ctrl.sv */
// Controller: sequences lookup, update, eviction loop and result transfer.
module bls_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_fire,
  input  bls_pkg::stat_t st,
  output bls_pkg::cmd_t  cmd,
  output logic          busy,
  output logic          res_valid
);
  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_CHECK, S_VSCAN, S_EVICT, S_OUT} state_t;
  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_nxt = S_APPLY;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = (st.req == bls_pkg::REQ_PUT) ? S_CHECK : S_OUT;
      end
      S_CHECK: begin
        if (st.over_budget) begin
          cmd.vic_start = 1'b1;
          state_nxt = S_VSCAN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_VSCAN: begin
        if (st.vic_done) begin
          state_nxt = st.have_victim ? S_EVICT : S_OUT;
        end else begin
          cmd.vic_step = 1'b1;
        end
      end
      S_EVICT: begin
        cmd.evict = 1'b1;
        state_nxt = S_CHECK;
      end
      S_OUT: begin
        if (out_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);
endmodule

/* rtl/bls_dp.sv */
// Datapath: slot table, serial key and victim scans, byte accounting.
module bls_dp #(
  parameter int ENTRIES   = bls_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = bls_pkg::KEY_BITS_DEF,
  parameter int SIZE_BITS = bls_pkg::SIZE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bls_pkg::cmd_t       cmd,
  output bls_pkg::stat_t      st,
  input  logic [2:0]          in_req,
  input  logic [KEY_BITS-1:0] in_key,
  input  logic [SIZE_BITS-1:0] in_size,
  input  logic [7:0]          in_fmt,
  input  logic                in_chk,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  output logic [2:0]          res_status,
  output logic [3:0]          res_slot,
  output logic                res_present,
  output logic                res_rebuild,
  output logic [31:0]         res_bytes
);
  localparam int IW = $clog2(ENTRIES);
  localparam int UB = bls_pkg::USED_BITS;

  // Slot table; valid bits reset, the rest written before use
  logic [ENTRIES-1:0]  valid_r;
  logic [KEY_BITS-1:0] key_r [ENTRIES];
  logic [SIZE_BITS-1:0] size_r [ENTRIES];
  logic [7:0]          fmt_r [ENTRIES];
  logic [ENTRIES-1:0]  pin_r, evc_r;
  logic [31:0]         rec_r [ENTRIES];
  logic [31:0]         clock_r;
  logic [UB-1:0]       used_r;
  logic [31:0]         budget_r;

  // Request capture and scan state
  logic [2:0]          req_r;
  logic [KEY_BITS-1:0] rkey_r;
  logic [SIZE_BITS-1:0] rsize_r;
  logic [7:0]          rfmt_r;
  logic                rchk_r;
  logic [IW:0]         idx_r;
  logic                hit_r, free_ok_r;
  logic [IW-1:0]       hit_idx_r, free_idx_r;
  logic                vhave_r;
  logic [IW-1:0]       vidx_r;
  logic [2:0]          status_r;
  logic [3:0]          slot_out_r;

  logic [IW-1:0] cur;
  assign cur = idx_r[IW-1:0];
  logic cand;
  assign cand = valid_r[cur] && !pin_r[cur] && !evc_r[cur];

  // Eviction only follows a put that was stored
  assign st.scan_done   = (idx_r == (IW+1)'(ENTRIES));
  assign st.vic_done    = (idx_r == (IW+1)'(ENTRIES));
  assign st.have_victim = vhave_r;
  assign st.over_budget = (used_r > UB'(budget_r)) && (status_r == bls_pkg::ST_OK);
  assign st.req         = req_r;

  logic size_over;
  assign size_over = UB'(rsize_r) > UB'(budget_r);

  // Slot written by a put: the matching slot, else the lowest free one
  logic [IW-1:0] put_slot;
  assign put_slot = hit_r ? hit_idx_r : free_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      clock_r  <= '0;
      used_r   <= '0;
      budget_r <= bls_pkg::BUDGET_RESET;
    end else begin
      if (cfg_we) budget_r <= cfg_data;
      // Capture request
      if (cmd.load) begin
        req_r     <= in_req;
        rkey_r    <= in_key;
        rsize_r   <= in_size;
        rfmt_r    <= in_fmt;
        rchk_r    <= in_chk;
        idx_r     <= '0;
        hit_r     <= 1'b0;
        free_ok_r <= 1'b0;
        hit_idx_r <= '0;
        free_idx_r <= '0;
      end
      // Key lookup, one slot per cycle
      if (cmd.scan_step) begin
        if (valid_r[cur] && key_r[cur] == rkey_r && !hit_r) begin
          hit_r <= 1'b1;
          hit_idx_r <= cur;
        end
        if (!valid_r[cur] && !free_ok_r) begin
          free_ok_r <= 1'b1;
          free_idx_r <= cur;
        end
        idx_r <= idx_r + 1'b1;
      end
      // Request effect
      if (cmd.apply) begin
        case (req_r)
          bls_pkg::REQ_PUT: begin
            slot_out_r <= '0;
            if (size_over) begin
              status_r <= bls_pkg::ST_TOO_LARGE;
            end else if (!hit_r && !free_ok_r) begin
              status_r <= bls_pkg::ST_FULL;
            end else begin
              status_r          <= bls_pkg::ST_OK;
              clock_r           <= clock_r + 32'd1;
              valid_r[put_slot] <= 1'b1;
              key_r[put_slot]   <= rkey_r;
              size_r[put_slot]  <= rsize_r;
              fmt_r[put_slot]   <= rfmt_r;
              pin_r[put_slot]   <= 1'b0;
              evc_r[put_slot]   <= 1'b0;
              rec_r[put_slot]   <= clock_r + 32'd1;
              if (hit_r && !evc_r[put_slot])
                used_r <= used_r - UB'(size_r[put_slot]) + UB'(rsize_r);
              else
                used_r <= used_r + UB'(rsize_r);
            end
          end
          bls_pkg::REQ_GET: begin
            if (!hit_r) begin
              status_r   <= bls_pkg::ST_NOT_FOUND;
              slot_out_r <= '0;
            end else if (evc_r[hit_idx_r]) begin
              status_r   <= bls_pkg::ST_EVICTED;
              slot_out_r <= '0;
            end else begin
              clock_r <= clock_r + 32'd1;
              rec_r[hit_idx_r] <= clock_r + 32'd1;
              if (rchk_r && fmt_r[hit_idx_r] != rfmt_r) begin
                status_r   <= bls_pkg::ST_FORMAT;
                slot_out_r <= '0;
              end else begin
                status_r   <= bls_pkg::ST_OK;
                slot_out_r <= 4'(hit_idx_r);
              end
            end
          end
          bls_pkg::REQ_PIN, bls_pkg::REQ_UNPIN: begin
            slot_out_r <= '0;
            if (!hit_r) begin
              status_r <= bls_pkg::ST_NOT_FOUND;
            end else begin
              status_r <= bls_pkg::ST_OK;
              pin_r[hit_idx_r] <= (req_r == bls_pkg::REQ_PIN);
            end
          end
          default: begin
            status_r   <= bls_pkg::ST_OK;
            slot_out_r <= '0;
          end
        endcase
      end
      // Victim scan: oldest unpinned live slot, lowest index on ties
      if (cmd.vic_start) begin
        idx_r   <= '0;
        vhave_r <= 1'b0;
        vidx_r  <= '0;
      end
      if (cmd.vic_step) begin
        if (cand && (!vhave_r || rec_r[cur] < rec_r[vidx_r])) begin
          vhave_r <= 1'b1;
          vidx_r  <= cur;
        end
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.evict) begin
        used_r <= used_r - UB'(size_r[vidx_r]);
        size_r[vidx_r] <= '0;
        evc_r[vidx_r]  <= 1'b1;
      end
    end
  end

  // Presence after the step: the key's slot is fixed once applied
  logic [IW-1:0] ps;
  logic pk;
  always_comb begin
    pk = hit_r || (req_r == bls_pkg::REQ_PUT && status_r == bls_pkg::ST_OK);
    ps = hit_r ? hit_idx_r : free_idx_r;
  end
  assign res_status  = status_r;
  assign res_slot    = slot_out_r;
  assign res_present = pk && !evc_r[ps];
  assign res_rebuild = pk && evc_r[ps];
  assign res_bytes   = (used_r[UB-1:32] != '0) ? 32'hFFFF_FFFF : used_r[31:0];
endmodule

/* rtl/budgeted_lru_store_with_pinning.sv */
// Top level: size-budgeted LRU store with pinning, stream in/out.
// A request is scanned across all slots and applied; a put is then checked against the budget,
// with a victim scan and eviction repeated while over budget, until no victim is found.
// One request at a time: no new request is taken until the result has left.
// The result is held until out_tready; a new request is taken the cycle after it leaves.
// Reset (rst_n, synchronous): all slots invalid, clock and usage zero, budget 65536.
module budgeted_lru_store_with_pinning #(
  parameter int ENTRIES   = bls_pkg::ENTRIES_DEF,
  parameter int KEY_BITS  = bls_pkg::KEY_BITS_DEF,
  parameter int SIZE_BITS = bls_pkg::SIZE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // tdata: req_type[2:0], key[34:3], size_bytes[66:35], format_tag[74:67], check_format[75]
  input  logic [79:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // tdata: status[2:0], slot_index[6:3], present[7], needs_rebuild[8], bytes_in_use[40:9]
  output logic [47:0] out_tdata,
  input  logic cfg_we,
  input  logic [31:0] cfg_data
);
  bls_pkg::cmd_t  cmd;
  bls_pkg::stat_t st;
  logic busy, rv;
  logic [2:0] rs;
  logic [3:0] rsl;
  logic rp, rr;
  logic [31:0] rb;

  assign in_tready  = !busy;
  assign out_tvalid = rv;

  bls_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_tvalid && in_tready),
    .out_fire(out_tvalid && out_tready),
    .st, .cmd, .busy, .res_valid(rv)
  );

  bls_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .st,
    .in_req(in_tdata[2:0]),
    .in_key(KEY_BITS'(in_tdata[34:3])),
    .in_size(SIZE_BITS'(in_tdata[66:35])),
    .in_fmt(in_tdata[74:67]),
    .in_chk(in_tdata[75]),
    .cfg_we, .cfg_data,
    .res_status(rs), .res_slot(rsl), .res_present(rp),
    .res_rebuild(rr), .res_bytes(rb)
  );

  assign out_tdata = {7'd0, rb, rr, rp, rsl, rs};
endmodule

/* rtl/bls_checker.sv */
// Port-level checker for the store, bound to the top level.
`include "budgeted_lru_store_with_pinning_assert.svh"
module bls_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic out_tvalid,
  input logic out_tready,
  input logic [47:0] out_tdata
);
  `BLS_ASSERT_IMP(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken while result pending")
  `BLS_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")
  `BLS_ASSERT_IMP(a_present_rebuild, clk, rst_n, out_tvalid, !(out_tdata[7] && out_tdata[8]), "present and rebuild both set")
  `BLS_ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid, out_tdata[2:0] <= bls_pkg::ST_FULL, "bad status")
endmodule

bind budgeted_lru_store_with_pinning bls_checker u_bls_checker (.*);

/* tb/budgeted_lru_store_with_pinning_tb.sv */
// Testbench for the budgeted LRU store: scoreboard predictor, stream driver and monitor.
module budgeted_lru_store_with_pinning_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD = 300;
  localparam logic [2:0] REQ_QUERY = 3'd4;

  typedef struct packed {
    logic       check_format;
    logic [7:0] format_tag;
    logic [31:0] size_bytes;
    logic [31:0] key;
    logic [2:0] req_type;
  } req_t;

  typedef struct packed {
    logic [31:0] bytes_in_use;
    logic       needs_rebuild;
    logic       present;
    logic [3:0] slot_index;
    logic [2:0] status;
  } resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  budgeted_lru_store_with_pinning uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the store
  logic [31:0] budget;
  logic        sv_valid [NSLOT];
  logic [31:0] sv_key [NSLOT];
  logic [63:0] sv_size [NSLOT];
  logic [7:0]  sv_fmt [NSLOT];
  logic        sv_pin [NSLOT];
  logic        sv_evict [NSLOT];
  logic [31:0] sv_recent [NSLOT];
  logic [31:0] use_clk;
  logic [63:0] used_bytes;

  req_t  pending_reqs[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    sent = 0;
  int    received = 0;
  int    cnt_evicted = 0, cnt_full = 0, cnt_big = 0, cnt_fmt = 0;
  bit    hold_req = 0;
  bit    in_taken = 0;

  function automatic int lookup(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (sv_valid[i] && sv_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void shadow_reset();
    budget = bls_pkg::BUDGET_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      sv_valid[i] = 0; sv_key[i] = 0; sv_size[i] = 0; sv_fmt[i] = 0;
      sv_pin[i] = 0; sv_evict[i] = 0; sv_recent[i] = 0;
    end
    use_clk = 0;
    used_bytes = 0;
  endfunction

  // Drop LRU unpinned live entries until usage fits or none can be dropped
  function automatic void trim_to_budget();
    int v;
    while (used_bytes > {32'd0, budget}) begin
      v = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!sv_valid[i] || sv_pin[i] || sv_evict[i]) continue;
        if (v < 0 || sv_recent[i] < sv_recent[v]) v = i;
      end
      if (v < 0) break;
      used_bytes -= sv_size[v];
      sv_size[v] = 0;
      sv_evict[v] = 1;
    end
  endfunction

  function automatic resp_t predict_store(req_t r);
    resp_t o;
    int s;
    o = '0;
    o.status = bls_pkg::ST_OK;
    case (r.req_type)
      bls_pkg::REQ_PUT: begin
        if ({32'd0, r.size_bytes} > {32'd0, budget}) o.status = bls_pkg::ST_TOO_LARGE;
        else begin
          s = lookup(r.key);
          if (s >= 0) begin
            if (!sv_evict[s]) used_bytes -= sv_size[s];
          end else begin
            for (int i = 0; i < NSLOT; i++)
              if (!sv_valid[i]) begin s = i; break; end
            if (s < 0) o.status = bls_pkg::ST_FULL;
          end
          if (s >= 0) begin
            use_clk++;
            sv_valid[s] = 1; sv_key[s] = r.key; sv_size[s] = 64'(r.size_bytes);
            sv_fmt[s] = r.format_tag; sv_pin[s] = 0; sv_evict[s] = 0;
            sv_recent[s] = use_clk;
            used_bytes += 64'(r.size_bytes);
            trim_to_budget();
          end
        end
      end
      bls_pkg::REQ_GET: begin
        s = lookup(r.key);
        if (s < 0) o.status = bls_pkg::ST_NOT_FOUND;
        else if (sv_evict[s]) o.status = bls_pkg::ST_EVICTED;
        else begin
          use_clk++;
          sv_recent[s] = use_clk;
          if (r.check_format && sv_fmt[s] != r.format_tag) o.status = bls_pkg::ST_FORMAT;
          else o.slot_index = s[3:0];
        end
      end
      bls_pkg::REQ_PIN, bls_pkg::REQ_UNPIN: begin
        s = lookup(r.key);
        if (s < 0) o.status = bls_pkg::ST_NOT_FOUND;
        else sv_pin[s] = (r.req_type == bls_pkg::REQ_PIN);
      end
      default: ;
    endcase
    s = lookup(r.key);
    o.present = (s >= 0) && !sv_evict[s];
    o.needs_rebuild = (s >= 0) && sv_evict[s];
    o.bytes_in_use = (used_bytes > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : used_bytes[31:0];
    return o;
  endfunction

  // Driver: hold each item until its transfer, random gaps between items
  int gap = 0;
  always @(negedge clk) begin
    bit taken;
    taken = in_taken;
    in_taken = 1'b0;
    if (rst_n) begin
      if (taken) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
      end
      if (in_tvalid && !taken) begin
        // keep offering the same item
      end else if (gap > 0) begin
        gap--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {4'd0, pending_reqs.pop_front()};
      end else
        in_tvalid <= 1'b0;
    end
  end

  // Receiver backpressure, with one long hold-off counted here
  int stall = 0;
  int hold_cnt = 0;
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = LONG_HOLD;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 7) == 0)
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    end
  end

  // Monitor: predict on each input transfer, compare each result transfer
  int idle_cycles = 0;
  always @(posedge clk) begin
    resp_t got, exp_r;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
      if (in_tvalid && in_tready) begin
        expected_resps.push_back(predict_store(in_tdata[75:0]));
        sent++;
        in_taken = 1'b1;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[40:0];
        received++;
        if (expected_resps.size() == 0) begin
          $error("result transfer with no prediction waiting");
          errors++;
        end else begin
          exp_r = expected_resps.pop_front();
          case (exp_r.status)
            bls_pkg::ST_EVICTED: cnt_evicted++;
            bls_pkg::ST_FULL: cnt_full++;
            bls_pkg::ST_TOO_LARGE: cnt_big++;
            bls_pkg::ST_FORMAT: cnt_fmt++;
            default: ;
          endcase
          if (got.status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, got.status); errors++;
          end
          if (got.slot_index !== exp_r.slot_index) begin
            $error("slot_index: expected %0d, got %0d", exp_r.slot_index, got.slot_index);
            errors++;
          end
          if (got.present !== exp_r.present) begin
            $error("present: expected %0d, got %0d", exp_r.present, got.present); errors++;
          end
          if (got.needs_rebuild !== exp_r.needs_rebuild) begin
            $error("needs_rebuild: expected %0d, got %0d", exp_r.needs_rebuild,
                   got.needs_rebuild);
            errors++;
          end
          if (got.bytes_in_use !== exp_r.bytes_in_use) begin
            $error("bytes_in_use: expected %0h, got %0h", exp_r.bytes_in_use,
                   got.bytes_in_use);
            errors++;
          end
        end
      end
    end
  end

  function automatic req_t mk(logic [2:0] t, logic [31:0] k, logic [31:0] sz,
                              logic [7:0] f, logic c);
    req_t r;
    r.req_type = t; r.key = k; r.size_bytes = sz; r.format_tag = f; r.check_format = c;
    return r;
  endfunction

  // Keys come mostly from a small pool so gets and replacements hit
  function automatic logic [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 32'h100 + $urandom_range(0, 23);
    if (sel == 7) return 32'hFFFF_FFF0 + $urandom_range(0, 15);
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return $urandom_range(0, budget / 4 + 1);
    if (sel < 8) return $urandom_range(budget / 2, budget);
    if (sel == 8) return budget + 1 + $urandom_range(0, 3);
    return $urandom;
  endfunction

  function automatic req_t random_req();
    logic [2:0] t;
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 8) t = bls_pkg::REQ_PUT;
    else if (sel < 13) t = bls_pkg::REQ_GET;
    else if (sel < 15) t = bls_pkg::REQ_PIN;
    else if (sel < 17) t = bls_pkg::REQ_UNPIN;
    else if (sel < 19) t = REQ_QUERY;
    else t = 3'($urandom_range(5, 7));
    return mk(t, pick_key(), pick_size(), 8'($urandom_range(0, 3) == 0 ? $urandom : 5),
              $urandom_range(0, 1));
  endfunction

  // Let everything drain, plus margin for the block's internal work
  task automatic drain();
    while (pending_reqs.size() > 0 || in_tvalid || expected_resps.size() > 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_budget(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    budget = v;
  endtask

  initial begin
    logic [31:0] budgets [5];
    shadow_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset budget, every operation and the corner cases
    pending_reqs.push_back(mk(bls_pkg::REQ_GET, 32'h0, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PIN, 32'hFFFF_FFFF, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_UNPIN, 32'h5, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h1, 32'd65537, 8'h11, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h1, 32'd30000, 8'hFF, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'hFFFF_FFFF, 32'd30000, 8'h00, 1));
    pending_reqs.push_back(mk(bls_pkg::REQ_PIN, 32'h1, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h2, 32'd10000, 8'h22, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_GET, 32'hFFFF_FFFF, 0, 8'h01, 1));
    pending_reqs.push_back(mk(bls_pkg::REQ_GET, 32'hFFFF_FFFF, 0, 8'h00, 1));
    pending_reqs.push_back(mk(bls_pkg::REQ_GET, 32'h2, 0, 8'h01, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h3, 32'd65536, 8'h33, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_GET, 32'h2, 0, 0, 0));
    pending_reqs.push_back(mk(REQ_QUERY, 32'h2, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PIN, 32'h2, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_UNPIN, 32'h1, 0, 0, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h1, 32'd0, 8'h44, 0));
    pending_reqs.push_back(mk(3'd5, 32'h1, 0, 0, 0));
    pending_reqs.push_back(mk(3'd7, 32'h2, 32'hFFFF_FFFF, 8'hFF, 1));
    for (int i = 0; i < 16; i++)
      pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h200 + i, 32'd0, 8'(i), 0));
    drain();

    // Huge budget: puts of the largest size, each followed by a pin, then a query
    write_budget(32'hFFFF_FFFF);
    for (int i = 0; i < 3; i++) begin
      pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h300 + i, 32'hFFFF_FFFF, 8'h1, 0));
      pending_reqs.push_back(mk(bls_pkg::REQ_PIN, 32'h300 + i, 0, 0, 0));
    end
    pending_reqs.push_back(mk(REQ_QUERY, 32'h300, 0, 0, 0));
    drain();

    // Zero budget: only empty puts fit; a rejected put must not evict
    write_budget(32'd0);
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h400, 32'd1, 8'h2, 0));
    pending_reqs.push_back(mk(bls_pkg::REQ_PUT, 32'h301, 32'd0, 8'h2, 0));
    drain();

    // Random phases across several budgets; the first one starts with a long hold-off
    budgets[0] = 32'd1000; budgets[1] = 32'd65536; budgets[2] = 32'hFFFF_FFFF;
    budgets[3] = $urandom; budgets[4] = 32'd100;
    for (int ph = 0; ph < 5; ph++) begin
      write_budget(budgets[ph]);
      for (int n = 0; n < 80; n++) pending_reqs.push_back(random_req());
      if (ph == 0) hold_req = 1'b1;
      drain();
    end

    $display("Ran %0d requests and checked %0d results under eight budget values,",
             sent, received);
    $display("seeing %0d evicted, %0d full, %0d too large and %0d format mismatch results",
             cnt_evicted, cnt_full, cnt_big, cnt_fmt);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
